@@ hdl/pfts_pkg.sv @@
// ----------------------------------------------------------------------------
// Function table search package
// Shared sizes, request and status codes, and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package pfts_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int IDENT_W     = 56;
   localparam int PLACE_W     = 32;
   localparam int RANK_W      = 6;
   localparam int OUT_IDX_W   = 6;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_CLASS  = 2'd1;
   localparam logic [1:0] REQ_VENDOR = 2'd2;

   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_ABSENT    = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_FOUND     = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   localparam logic [31:0] ABSENT_ID       = 32'hFFFF_FFFF;
   localparam int          MF_BIT_POS      = 23;
   localparam logic [7:0]  BRIDGE_CLASS    = 8'h06;
   localparam logic [7:0]  BRIDGE_SUBCLASS = 8'h04;

   typedef enum logic [1:0] {
      S_IDLE,
      S_INSERT,
      S_SCAN
   } state_type;

   typedef struct packed {
      logic load;
      logic insert;
      logic scan;
      logic found;
      logic miss;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_search;
      logic hit;
      logic scan_end;
   } dp_status_type;

   // Reported indexes are the low six bits of the table index.
   function automatic logic [OUT_IDX_W-1:0] fit_index(input logic [CNT_W-1:0] value);
      logic [CNT_W+OUT_IDX_W-1:0] wide;
      wide = {{OUT_IDX_W{1'b0}}, value};
      return wide[OUT_IDX_W-1:0];
   endfunction

endpackage

@@ hdl/pfts_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pfts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/pfts_datapath.sv @@
// ----------------------------------------------------------------------------
// Function table datapath
// Request registers, the two table memories, the scan address and match
// counter, and the result registers.
// ----------------------------------------------------------------------------
module pfts_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  pfts_pkg::ctrl_cmd_type cmd,
   output pfts_pkg::dp_status_type status,
   input  logic [1:0]             req_type,
   input  logic [7:0]             req_bus_number,
   input  logic [4:0]             req_slot_number,
   input  logic [2:0]             req_function_number,
   input  logic [31:0]            req_id_word,
   input  logic [31:0]            req_class_word,
   input  logic [31:0]            req_header_word,
   input  logic [31:0]            req_line_word,
   input  logic signed [6:0]      req_parent_entry,
   input  logic [5:0]             req_match_rank,
   output logic [2:0]             rsp_status,
   output logic [5:0]             rsp_entry_index,
   output logic [7:0]             rsp_found_bus,
   output logic [4:0]             rsp_found_slot,
   output logic [2:0]             rsp_found_function,
   output logic [7:0]             rsp_found_irq_pin,
   output logic                   rsp_found_multifunction,
   output logic signed [6:0]      rsp_found_parent,
   output logic                   rsp_is_bridge
);
   import pfts_pkg::*;

   // Latched request.
   logic [1:0]        type_ff;
   logic [7:0]        bus_ff;
   logic [4:0]        slot_ff;
   logic [2:0]        func_ff;
   logic [31:0]       id_ff;
   logic [23:0]       cls_ff;
   logic              mf_ff;
   logic [7:0]        pin_ff;
   logic [6:0]        parent_ff;
   logic [RANK_W-1:0] rank_ff;

   // Table and scan state.
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  addr_ff, addr_in;
   logic [CNT_W-1:0]  rd_idx_ff;
   logic              rd_valid_ff, rd_valid_in;
   logic [RANK_W-1:0] seen_ff, seen_in;

   logic [IDENT_W-1:0] ident_rd;
   logic [PLACE_W-1:0] place_rd;
   logic [IDENT_W-1:0] ident_wr;
   logic [PLACE_W-1:0] place_wr;

   // Next result beat.
   logic [2:0]           res_status_in;
   logic [OUT_IDX_W-1:0] res_index_in;
   logic [7:0]           res_bus_in;
   logic [4:0]           res_slot_in;
   logic [2:0]           res_func_in;
   logic [7:0]           res_pin_in;
   logic                 res_mf_in;
   logic [6:0]           res_parent_in;
   logic                 res_bridge_in;

   logic rd_issue;
   logic more_entries;
   logic match;
   logic absent;
   logic full;
   logic do_write;
   logic bridge;

   assign more_entries = addr_ff < count_ff;
   assign rd_issue     = cmd.scan && more_entries;

   assign match = (type_ff == REQ_CLASS) ? (ident_rd[55:32] == cls_ff)
                                         : (ident_rd[31:0] == id_ff);

   assign status.is_search = (type_ff == REQ_CLASS) || (type_ff == REQ_VENDOR);
   assign status.hit       = rd_valid_ff && match && (seen_ff == rank_ff);
   assign status.scan_end  = !rd_valid_ff && !more_entries;

   assign absent   = id_ff == ABSENT_ID;
   assign full     = count_ff == CNT_W'(TABLE_DEPTH);
   assign do_write = cmd.insert && !absent && !full;
   assign bridge   = (cls_ff[23:16] == BRIDGE_CLASS) && (cls_ff[15:8] == BRIDGE_SUBCLASS);

   assign ident_wr = {cls_ff, id_ff};
   assign place_wr = {parent_ff, mf_ff, pin_ff, func_ff, slot_ff, bus_ff};

   pfts_ram #(.WIDTH(IDENT_W), .DEPTH(TABLE_DEPTH)) u_ident_ram (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (ident_wr),
      .rd_en   (rd_issue),
      .rd_addr (addr_ff[IDX_W-1:0]),
      .rd_data (ident_rd)
   );

   pfts_ram #(.WIDTH(PLACE_W), .DEPTH(TABLE_DEPTH)) u_place_ram (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (place_wr),
      .rd_en   (rd_issue),
      .rd_addr (addr_ff[IDX_W-1:0]),
      .rd_data (place_rd)
   );

   always_comb begin
      count_in    = count_ff;
      addr_in     = addr_ff;
      rd_valid_in = rd_issue;
      seen_in     = seen_ff;
      if (do_write) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.load) begin
         addr_in     = '0;
         rd_valid_in = 1'b0;
         seen_in     = '0;
      end else begin
         if (rd_issue) begin
            addr_in = addr_ff + CNT_W'(1);
         end
         // A match that is not yet the requested one only bumps the count.
         if (rd_valid_ff && match && (seen_ff != rank_ff)) begin
            seen_in = seen_ff + RANK_W'(1);
         end
      end
   end

   // Result fields default to zero and not found; an insert or a hit fills
   // in what it has.
   always_comb begin
      res_status_in = ST_NOT_FOUND;
      res_index_in  = '0;
      res_bus_in    = '0;
      res_slot_in   = '0;
      res_func_in   = '0;
      res_pin_in    = '0;
      res_mf_in     = 1'b0;
      res_parent_in = '0;
      res_bridge_in = 1'b0;
      if (cmd.insert) begin
         if (absent) begin
            res_status_in = ST_ABSENT;
         end else if (full) begin
            res_status_in = ST_FULL;
         end else begin
            res_status_in = ST_INSERTED;
            res_index_in  = fit_index(count_ff);
            res_bridge_in = bridge;
         end
      end else if (cmd.found) begin
         res_status_in = ST_FOUND;
         res_index_in  = fit_index(rd_idx_ff);
         res_bus_in    = place_rd[7:0];
         res_slot_in   = place_rd[12:8];
         res_func_in   = place_rd[15:13];
         res_pin_in    = place_rd[23:16];
         res_mf_in     = place_rd[24];
         res_parent_in = place_rd[31:25];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         addr_ff     <= '0;
         rd_valid_ff <= 1'b0;
         seen_ff     <= '0;
      end else begin
         count_ff    <= count_in;
         addr_ff     <= addr_in;
         rd_valid_ff <= rd_valid_in;
         seen_ff     <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_issue) begin
         rd_idx_ff <= addr_ff;
      end
      if (cmd.load) begin
         type_ff   <= req_type;
         bus_ff    <= req_bus_number;
         slot_ff   <= req_slot_number;
         func_ff   <= req_function_number;
         id_ff     <= req_id_word;
         cls_ff    <= req_class_word[31:8];
         mf_ff     <= req_header_word[MF_BIT_POS];
         pin_ff    <= req_line_word[15:8];
         parent_ff <= req_parent_entry;
         rank_ff   <= req_match_rank;
      end
      if (cmd.insert || cmd.found || cmd.miss) begin
         rsp_status              <= res_status_in;
         rsp_entry_index         <= res_index_in;
         rsp_found_bus           <= res_bus_in;
         rsp_found_slot          <= res_slot_in;
         rsp_found_function      <= res_func_in;
         rsp_found_irq_pin       <= res_pin_in;
         rsp_found_multifunction <= res_mf_in;
         rsp_found_parent        <= res_parent_in;
         rsp_is_bridge           <= res_bridge_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count beyond table depth");

   assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> seen_ff <= rank_ff)
      else $error("match count passed the requested rank");

   assert property (@(posedge clock) disable iff (reset)
      do_write |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("stored entry not counted");

endmodule

@@ hdl/pfts_ctrl.sv @@
// ----------------------------------------------------------------------------
// Function table controller
// Sequences inserts and scans and raises the result strobe.
// ----------------------------------------------------------------------------
module pfts_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [1:0]              req_type,
   input  pfts_pkg::dp_status_type status,
   output pfts_pkg::ctrl_cmd_type  cmd,
   output logic                    busy,
   output logic                    rsp_strobe
);
   import pfts_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_strobe_ff, rsp_strobe_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = (req_type == REQ_INSERT) ? S_INSERT : S_SCAN;
            end
         end
         S_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = S_IDLE;
         end
         S_SCAN: begin
            priority if (!status.is_search) begin
               cmd.miss = 1'b1;
               state_in = S_IDLE;
            end else if (status.hit) begin
               cmd.found = 1'b1;
               state_in  = S_IDLE;
            end else if (status.scan_end) begin
               cmd.miss = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_strobe_in = cmd.insert || cmd.found || cmd.miss;
   end

   assign rsp_strobe = rsp_strobe_ff;

   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted request did not raise busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while still working");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results in a row");

endmodule

@@ hdl/pci_function_table_search.sv @@
// ----------------------------------------------------------------------------
// PCI function table search
// Keeps a table of enumerated bus functions, filled in arrival order, and
// answers searches by class triple or by vendor and device pair.
// ----------------------------------------------------------------------------
//
//   Channel    Handshake              Beat contents
//   ---------  ---------------------  ---------------------------------------
//   request    start high, busy low   req_type and the request fields
//   result     rsp_strobe, one cycle  rsp_status, index and found fields
//
// An insert raises busy in the insert state and its result strobe follows
// in the next cycle. A find reads the table memories one entry per cycle
// through their single read port until it meets a match of the requested
// rank or the end of the entries; the result strobe is registered after
// that. The unused request type answers as not found without reading the
// table. The request after a result can be accepted in the strobe cycle
// itself. Reset clears only the entry count, scan state and control state;
// the table memories are not cleared, since only entries below the count
// are ever read. The receiver cannot stall: each result beat is valid for
// exactly one cycle.
//
module pci_function_table_search (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_type,
   input  logic [7:0]        req_bus_number,
   input  logic [4:0]        req_slot_number,
   input  logic [2:0]        req_function_number,
   input  logic [31:0]       req_id_word,
   input  logic [31:0]       req_class_word,
   input  logic [31:0]       req_header_word,
   input  logic [31:0]       req_line_word,
   input  logic signed [6:0] req_parent_entry,
   input  logic [5:0]        req_match_rank,
   output logic              rsp_strobe,
   output logic [2:0]        rsp_status,
   output logic [5:0]        rsp_entry_index,
   output logic [7:0]        rsp_found_bus,
   output logic [4:0]        rsp_found_slot,
   output logic [2:0]        rsp_found_function,
   output logic [7:0]        rsp_found_irq_pin,
   output logic              rsp_found_multifunction,
   output logic signed [6:0] rsp_found_parent,
   output logic              rsp_is_bridge
);
   import pfts_pkg::*;

   // The controller only sees start, the request type and the datapath status;
   // everything it asks of the datapath travels in one command bundle.
   ctrl_cmd_type  cmd;
   dp_status_type status;

   pfts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_type   (req_type),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // The datapath holds the request, the table memories and the result
   // registers, which stay stable from one result beat to the next.
   pfts_datapath u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .req_type                (req_type),
      .req_bus_number          (req_bus_number),
      .req_slot_number         (req_slot_number),
      .req_function_number     (req_function_number),
      .req_id_word             (req_id_word),
      .req_class_word          (req_class_word),
      .req_header_word         (req_header_word),
      .req_line_word           (req_line_word),
      .req_parent_entry        (req_parent_entry),
      .req_match_rank          (req_match_rank),
      .rsp_status              (rsp_status),
      .rsp_entry_index         (rsp_entry_index),
      .rsp_found_bus           (rsp_found_bus),
      .rsp_found_slot          (rsp_found_slot),
      .rsp_found_function      (rsp_found_function),
      .rsp_found_irq_pin       (rsp_found_irq_pin),
      .rsp_found_multifunction (rsp_found_multifunction),
      .rsp_found_parent        (rsp_found_parent),
      .rsp_is_bridge           (rsp_is_bridge)
   );

endmodule
